// File: rtl/core/pcmu_pkg.sv
package pcmu_pkg;

  localparam int MAX_CHANNELS_DEF = 8;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_BYTES_PER_SAMPLE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHANNELS_IN_FRAME  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_CHANNEL_ONLY = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LIMIT        = 2'd3;

  localparam logic [2:0] BYTES_PER_SAMPLE_RST  = 3'd2;
  localparam logic [3:0] CHANNELS_IN_FRAME_RST = 4'd2;

  localparam logic [2:0] BYTES_MIN = 3'd1;
  localparam logic [2:0] BYTES_MAX = 3'd4;
  localparam logic [8:0] U8_OFFSET = 9'd255;

  typedef struct packed {
    logic [2:0]  bytes_per_sample;
    logic [3:0]  channels_in_frame;
    logic        first_channel_only;
    logic [31:0] frame_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [2:0]         channel_index;
    logic               frame_end;
    logic               stream_end;
  } result_t;

endpackage

// File: rtl/core/pcmu_cfg_regs.sv
module pcmu_cfg_regs
  import pcmu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_BYTES_PER_SAMPLE:   cfg_nxt.bytes_per_sample   = cfg_wdata[2:0];
        CFG_CHANNELS_IN_FRAME:  cfg_nxt.channels_in_frame  = cfg_wdata[3:0];
        CFG_FIRST_CHANNEL_ONLY: cfg_nxt.first_channel_only = cfg_wdata[0];
        CFG_FRAME_LIMIT:        cfg_nxt.frame_limit        = cfg_wdata[31:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bytes_per_sample   <= BYTES_PER_SAMPLE_RST;
      cfg_r.channels_in_frame  <= CHANNELS_IN_FRAME_RST;
      cfg_r.first_channel_only <= 1'b0;
      cfg_r.frame_limit        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/pcmu_in_reg.sv
module pcmu_in_reg
  import pcmu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/core/pcmu_unpack.sv
module pcmu_unpack
  import pcmu_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     advance,
  input  in_item_t item,
  output logic     res_valid,
  output result_t  res
);

  localparam int          CH_CAP_I = (MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS;
  localparam logic [3:0]  CH_CAP   = 4'(CH_CAP_I);

  logic [1:0]  bp_r, bp_nxt;
  logic [2:0]  ch_r, ch_nxt;
  logic [31:0] fd_r, fd_nxt;
  logic [23:0] part_r, part_nxt;

  logic [1:0]  bp_e;
  logic [2:0]  ch_e;
  logic [31:0] fd_e;
  logic [23:0] part_e;

  logic        active;
  logic [2:0]  nb;
  logic [2:0]  nb_m1;
  logic [1:0]  pad_bytes;
  logic [3:0]  nch;
  logic        gather;
  logic [31:0] word;
  logic [8:0]  u8_diff;
  logic [31:0] value;
  logic        last_ch;
  logic        last_frame;
  logic        emit;

  assign bp_e   = item.start_stream ? '0 : bp_r;
  assign ch_e   = item.start_stream ? '0 : ch_r;
  assign fd_e   = item.start_stream ? '0 : fd_r;
  assign part_e = item.start_stream ? '0 : part_r;

  assign active = fd_e < cfg.frame_limit;

  always_comb begin
    nb = cfg.bytes_per_sample;
    if (cfg.bytes_per_sample < BYTES_MIN) begin
      nb = BYTES_MIN;
    end else if (cfg.bytes_per_sample > BYTES_MAX) begin
      nb = BYTES_MAX;
    end
  end

  always_comb begin
    nch = cfg.channels_in_frame;
    if (cfg.channels_in_frame == 4'd0) begin
      nch = 4'd1;
    end else if (cfg.channels_in_frame > CH_CAP) begin
      nch = CH_CAP;
    end
  end

  assign nb_m1     = nb - 3'd1;
  assign pad_bytes = 2'(BYTES_MAX - nb);
  assign gather    = {1'b0, bp_e} < nb_m1;

  assign word    = {8'd0, part_e} | ({24'd0, item.data_byte} << {nb_m1[1:0], 3'b000});
  assign u8_diff = {item.data_byte, 1'b0} - U8_OFFSET;
  assign value   = (nb == BYTES_MIN) ? {u8_diff, 23'd0} : (word << {pad_bytes, 3'b000});

  assign last_ch    = {1'b0, ch_e} >= (nch - 4'd1);
  assign last_frame = last_ch && ((fd_e + 32'd1) == cfg.frame_limit);
  assign emit       = !cfg.first_channel_only || (ch_e == 3'd0);

  always_comb begin
    bp_nxt   = bp_e;
    ch_nxt   = ch_e;
    fd_nxt   = fd_e;
    part_nxt = part_e;
    if (active) begin
      if (gather) begin
        part_nxt = part_e | ({16'd0, item.data_byte} << {bp_e, 3'b000});
        bp_nxt   = bp_e + 2'd1;
      end else begin
        part_nxt = '0;
        bp_nxt   = '0;
        if (last_ch) begin
          ch_nxt = '0;
          fd_nxt = fd_e + 32'd1;
        end else begin
          ch_nxt = ch_e + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r   <= '0;
      ch_r   <= '0;
      fd_r   <= '0;
      part_r <= '0;
    end else if (advance) begin
      bp_r   <= bp_nxt;
      ch_r   <= ch_nxt;
      fd_r   <= fd_nxt;
      part_r <= part_nxt;
    end
  end

  assign res_valid         = advance && active && !gather && emit;
  assign res.sample_value  = value;
  assign res.channel_index = ch_e;
  assign res.frame_end     = last_ch;
  assign res.stream_end    = last_frame;

endmodule

// File: rtl/core/pcmu_out_reg.sv
module pcmu_out_reg
  import pcmu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

// File: rtl/core/pcm_byte_stream_sample_unpacker_core.sv
// Linear PCM byte stream sample unpacker.
// Input stream: one byte of the wave data chunk per request on in_tdata; in_tuser
// set on a request clears the byte, channel and frame counters before that byte.
// Output stream: one decoded sample per request, a signed Q1.31 value on
// out_tdata, channel number and final-frame flag on out_tuser, and out_tlast on
// the last channel of each frame. With first_channel_only set, only channel 0
// samples appear. Bytes that do not finish a sample, and all bytes past the
// configured frame count, give no output request.
// Path: a byte accepted into the input register is decoded combinationally and
// its sample loads the output register when the output is free. Throughput:
// one byte per cycle unless the output stalls; the counter loop is combinational.
// Config: write registers through cfg_wr_en/cfg_addr/cfg_wdata while the stream
// is idle. Reset (rst_n low, synchronous) restores register defaults, clears
// all counters and empties both the input and output registers.
// Stall: while out_tready is low and a sample waits, the byte in the input
// register holds, whether or not it finishes a sample, and in_tready drops.
module pcm_byte_stream_sample_unpacker_core
  import pcmu_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] data_byte
  input  logic                  in_tuser,    // [0] start_stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,   // [31:0] sample_value
  output logic [3:0]            out_tuser,   // [2:0] channel_index, [3] stream_end
  output logic                  out_tlast,   // frame_end
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.data_byte    = in_tdata;
  assign in_item.start_stream = in_tuser;

  assign advance = item_valid && (!out_tvalid || out_tready);

  pcmu_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcmu_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pcmu_unpack #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  pcmu_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.sample_value;
  assign out_tuser = {out_res.stream_end, out_res.channel_index};
  assign out_tlast = out_res.frame_end;

  a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_tvalid || out_tready))
    else $error("result loaded over a waiting sample");

  a_stream_end_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tlast)
    else $error("final-frame flag without frame end");

  a_no_result_without_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(item_valid))
    else $error("sample appeared without a held byte");

endmodule

// File: tb/tb_pcm_byte_stream_sample_unpacker_core.sv
`timescale 1ns / 1ps

module tb_pcm_byte_stream_sample_unpacker_core;
  import pcmu_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;    // [7:0] data_byte
  logic                  in_tuser = 1'b0;  // [0] start_stream
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;        // [31:0] sample_value
  logic [3:0]            out_tuser;        // [2:0] channel_index, [3] stream_end
  logic                  out_tlast;        // frame_end
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pcm_byte_stream_sample_unpacker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb_pcm_byte_stream_sample_unpacker_core failed");
    $finish;
  end

  in_item_t bytes_to_send[$];
  result_t  samples_due[$];
  in_item_t held_byte;
  bit       sending = 1'b0;
  bit       steady = 1'b0;
  int       mismatches = 0;
  result_t  got_sample;
  result_t  want_sample;

  // shadow registers and decoder state
  logic [2:0]  sh_bytes = BYTES_PER_SAMPLE_RST;
  logic [3:0]  sh_chans = CHANNELS_IN_FRAME_RST;
  logic        sh_ch0_only = 1'b0;
  logic [31:0] sh_frame_limit = '0;
  logic [1:0]  byte_pos = '0;
  logic [2:0]  chan_pos = '0;
  logic [31:0] frames_done = '0;
  logic [23:0] partial_word = '0;

  function automatic void unpack_byte(in_item_t it);
    int          nbe;
    int          nce;
    logic [31:0] word;
    logic [31:0] value;
    logic        last_ch;
    result_t     r;
    if (it.start_stream) begin
      byte_pos = '0;
      chan_pos = '0;
      frames_done = '0;
      partial_word = '0;
    end
    if (frames_done >= sh_frame_limit) return;
    nbe = (sh_bytes == 0) ? 1 : (sh_bytes > 4) ? 4 : int'(sh_bytes);
    nce = (sh_chans == 0) ? 1 : (sh_chans > 8) ? 8 : int'(sh_chans);
    if (int'(byte_pos) < nbe - 1) begin
      partial_word = partial_word | (24'(it.data_byte) << (8 * byte_pos));
      byte_pos = byte_pos + 2'd1;
      return;
    end
    if (nbe == 1) begin
      value = ((32'(it.data_byte) << 1) - 32'd255) << 23;
    end else begin
      word = 32'(partial_word) | (32'(it.data_byte) << (8 * (nbe - 1)));
      value = word << (8 * (4 - nbe));
    end
    byte_pos = '0;
    partial_word = '0;
    last_ch = int'(chan_pos) >= nce - 1;
    r.sample_value = value;
    r.channel_index = chan_pos;
    r.frame_end = last_ch;
    r.stream_end = last_ch && (frames_done + 32'd1 == sh_frame_limit);
    if (last_ch) begin
      chan_pos = '0;
      frames_done = frames_done + 32'd1;
    end else begin
      chan_pos = chan_pos + 3'd1;
    end
    if (!sh_ch0_only || r.channel_index == 3'd0) samples_due.push_back(r);
  endfunction

  task automatic note_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s sample: expected value=%h ch=%0d frame_end=%0b stream_end=%0b, got value=%h ch=%0d frame_end=%0b stream_end=%0b",
               what, want.sample_value, want.channel_index, want.frame_end, want.stream_end,
               got.sample_value, got.channel_index, got.frame_end, got.stream_end);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      sending = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        unpack_byte(held_byte);
        sending = 1'b0;
      end
      if (!in_tvalid || in_tready) begin
        if (bytes_to_send.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
          held_byte = bytes_to_send.pop_front();
          sending = 1'b1;
          in_tvalid <= 1'b1;
          in_tdata <= held_byte.data_byte;
          in_tuser <= held_byte.start_stream;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_sample.sample_value = out_tdata;
        got_sample.channel_index = out_tuser[2:0];
        got_sample.stream_end = out_tuser[3];
        got_sample.frame_end = out_tlast;
        if (samples_due.size() == 0) begin
          note_mismatch("unexpected", '0, got_sample);
        end else begin
          want_sample = samples_due.pop_front();
          if (got_sample.sample_value !== want_sample.sample_value ||
              got_sample.channel_index !== want_sample.channel_index ||
              got_sample.frame_end !== want_sample.frame_end ||
              got_sample.stream_end !== want_sample.stream_end)
            note_mismatch("wrong", want_sample, got_sample);
        end
      end
      out_tready <= steady || $urandom_range(99) >= 15;
    end
  end

  task automatic push_byte(logic [7:0] b, logic start);
    in_item_t it;
    it.data_byte = b;
    it.start_stream = start;
    bytes_to_send.push_back(it);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || sending || samples_due.size() != 0)
      @(posedge clk);
  endtask

  // drain, then let bytes that give no sample clear the pipeline
  task automatic settle();
    wait_drained();
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_BYTES_PER_SAMPLE:   sh_bytes = val[2:0];
      CFG_CHANNELS_IN_FRAME:  sh_chans = val[3:0];
      CFG_FIRST_CHANNEL_ONLY: sh_ch0_only = val[0];
      CFG_FRAME_LIMIT:        sh_frame_limit = val;
      default: ;
    endcase
  endtask

  task automatic stream_phase(input bit fresh, input bit pause_midway, output int counted);
    int          nbe;
    int          nce;
    int          frames;
    int          total;
    int          i;
    logic [2:0]  nb;
    logic [3:0]  nc;
    logic [31:0] lim;
    settle();
    nb = ($urandom_range(9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
    nc = ($urandom_range(9) < 8) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
    frames = $urandom_range(1, 8);
    case ($urandom_range(9))
      0: lim = 32'hFFFF_FFFF;
      1: lim = $urandom;
      2: lim = 32'd0;
      3: lim = 32'(frames - 1);
      default: lim = 32'(frames);
    endcase
    write_reg(CFG_BYTES_PER_SAMPLE, 32'(nb));
    write_reg(CFG_CHANNELS_IN_FRAME, 32'(nc));
    write_reg(CFG_FIRST_CHANNEL_ONLY, 32'($urandom_range(1)));
    write_reg(CFG_FRAME_LIMIT, lim);
    nbe = (nb == 0) ? 1 : (nb > 4) ? 4 : int'(nb);
    nce = (nc == 0) ? 1 : (nc > 8) ? 8 : int'(nc);
    total = frames * nbe * nce;
    if ($urandom_range(99) < 15) total -= $urandom_range(1, nbe);
    for (i = 0; i < total; i++) begin
      if (pause_midway && i == total / 2) wait_drained();
      push_byte(pick_byte(), (i == 0 && fresh) || $urandom_range(199) == 0);
    end
    counted = (lim == 0) ? 0 : total;
  endtask

  initial begin
    int sent;
    int n;
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // frame limit still zero after reset: nothing comes out
    push_byte(8'h5A, 1'b1);
    push_byte(8'hA5, 1'b0);
    settle();

    // unsigned 8-bit extremes, fourth byte falls past the last frame
    write_reg(CFG_BYTES_PER_SAMPLE, 32'd1);
    write_reg(CFG_CHANNELS_IN_FRAME, 32'd1);
    write_reg(CFG_FRAME_LIMIT, 32'd3);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    settle();

    // 32-bit most negative and most positive
    write_reg(CFG_BYTES_PER_SAMPLE, 32'd4);
    write_reg(CFG_CHANNELS_IN_FRAME, 32'd2);
    write_reg(CFG_FRAME_LIMIT, 32'd1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    settle();

    // zero size and zero channel count act as one
    write_reg(CFG_BYTES_PER_SAMPLE, 32'd0);
    write_reg(CFG_CHANNELS_IN_FRAME, 32'd0);
    write_reg(CFG_FRAME_LIMIT, 32'd2);
    push_byte(8'h01, 1'b1);
    push_byte(8'hFE, 1'b0);
    settle();

    // oversize settings clamp; channel 1 is consumed silently
    write_reg(CFG_BYTES_PER_SAMPLE, 32'd7);
    write_reg(CFG_CHANNELS_IN_FRAME, 32'd15);
    write_reg(CFG_FIRST_CHANNEL_ONLY, 32'd1);
    write_reg(CFG_FRAME_LIMIT, 32'hFFFF_FFFF);
    push_byte(8'h12, 1'b1);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(8'h9A, 1'b0);
    push_byte(8'hBC, 1'b0);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hF0, 1'b0);

    sent = 0;
    phase = 0;
    while (sent < 1250) begin
      steady = (phase >= 4 && phase < 8);
      stream_phase(phase == 0 ? 1'b0 : ($urandom_range(4) != 0),
                   phase == 2 || $urandom_range(9) == 0, n);
      sent += n;
      phase++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (samples_due.size() != 0) note_mismatch("missing", samples_due[0], '0);
    if (mismatches == 0) begin
      $display("tb_pcm_byte_stream_sample_unpacker_core passed");
    end else begin
      $display("tb_pcm_byte_stream_sample_unpacker_core failed");
    end
    $finish;
  end

endmodule
